>>> design/sdz_pkg.sv
package sdz_pkg;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int FS_W      = 7;
  localparam int QUO_W     = 7;
  localparam int AXIS_W    = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER  = 3'd0,
    CFG_NEG     = 3'd1,
    CFG_POS     = 3'd2,
    CFG_MARGIN  = 3'd3,
    CFG_FULL    = 3'd4,
    CFG_INVERT  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic            neg;
    logic            zero;
    logic [FS_W-1:0] fs;
  } div_ctl_t;

endpackage

>>> design/sdz_in_if.sv
interface sdz_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

>>> design/sdz_out_if.sv
interface sdz_out_if
  import sdz_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [AXIS_W-1:0] axis_value;

  modport source (output valid, output axis_value, input ready);
  modport sink (input valid, input axis_value, output ready);
endinterface

>>> design/sdz_cfg_if.sv
interface sdz_cfg_if
  import sdz_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/sdz_divider.sv
module sdz_divider
  import sdz_pkg::*;
#(
  parameter int NUM_W = 19
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [NUM_W-1:0]         in_num,
  input  logic [CFG_W-1:0]         in_den,
  input  div_ctl_t                 in_ctl,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [AXIS_W-1:0] out_value
);

  localparam int NSTG = QUO_W + 1;

  logic [NSTG-1:0]  v_r;
  logic [NSTG:0]    rdy;
  logic [NUM_W-1:0] rem_r [NSTG];
  logic [QUO_W-1:0] q_r   [NSTG];
  logic [CFG_W-1:0] den_r [NSTG];
  div_ctl_t         ctl_r [NSTG];
  logic             sat_r [NSTG];

  logic                     out_v_r;
  logic signed [AXIS_W-1:0] out_value_r;
  logic [QUO_W-1:0]         mag;
  logic [AXIS_W-1:0]        mag_ext;
  logic [AXIS_W-1:0]        res_nxt;

  always_comb begin
    rdy[NSTG] = !out_v_r || out_ready;
    for (int j = NSTG - 1; j >= 0; j--) begin
      rdy[j] = !v_r[j] || rdy[j+1];
    end
  end

  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int j = 1; j < NSTG; j++) begin
        if (rdy[j]) begin
          v_r[j] <= v_r[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      rem_r[0] <= in_num;
      q_r[0]   <= '0;
      den_r[0] <= in_den;
      ctl_r[0] <= in_ctl;
      sat_r[0] <= in_num >= (NUM_W'(in_den) << QUO_W);
    end
    for (int j = 1; j < NSTG; j++) begin
      if (rdy[j]) begin
        den_r[j] <= den_r[j-1];
        ctl_r[j] <= ctl_r[j-1];
        sat_r[j] <= sat_r[j-1];
        if (rem_r[j-1] >= (NUM_W'(den_r[j-1]) << (QUO_W - j))) begin
          rem_r[j] <= rem_r[j-1] - (NUM_W'(den_r[j-1]) << (QUO_W - j));
          q_r[j]   <= q_r[j-1] | (QUO_W'(1) << (QUO_W - j));
        end else begin
          rem_r[j] <= rem_r[j-1];
          q_r[j]   <= q_r[j-1];
        end
      end
    end
  end

  always_comb begin
    if (ctl_r[NSTG-1].zero) begin
      mag = '0;
    end else if (sat_r[NSTG-1] || (q_r[NSTG-1] > ctl_r[NSTG-1].fs)) begin
      mag = ctl_r[NSTG-1].fs;
    end else begin
      mag = q_r[NSTG-1];
    end
    mag_ext = AXIS_W'(mag);
    res_nxt = ctl_r[NSTG-1].neg ? (~mag_ext + AXIS_W'(1)) : mag_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy[NSTG]) begin
      out_v_r <= v_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG]) begin
      out_value_r <= $signed(res_nxt);
    end
  end

  assign out_valid = out_v_r;
  assign out_value = out_value_r;

endmodule

>>> design/stick_deadzone_scaler_top.sv
// Channel  Role    Payload                 Handshake
// in_ch    sink    sample                  valid / ready
// out_ch   source  axis_value (signed)     valid / ready
// cfg_ch   sink    index, data             valid / ready (ready always high)
//
// One item enters per cycle while the pipeline is not stalled by back-pressure from the output.
// The pipeline is four front stages (deviation, magnitude, excess, multiply) followed by
// one saturation stage, seven restoring division stages, one bit each, and the output stage.
// Synchronous active-low reset clears the valid bits and loads the register reset values.
// Every stage holds its item while the stage after it is full and stalled.
module stick_deadzone_scaler_top
  import sdz_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input logic        clk,
  input logic        rst_n,
  sdz_in_if.sink     in_ch,
  sdz_out_if.source  out_ch,
  sdz_cfg_if.sink    cfg_ch
);

  localparam int MAG_W = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
  localparam int NUM_W = MAG_W + FS_W;

  logic [CFG_W-1:0] center_r;
  logic [CFG_W-1:0] neg_span_r;
  logic [CFG_W-1:0] pos_span_r;
  logic [CFG_W-1:0] margin_r;
  logic [FS_W-1:0]  fs_r;
  logic             inv_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r   <= CFG_W'(2048);
      neg_span_r <= CFG_W'(115);
      pos_span_r <= CFG_W'(115);
      margin_r   <= CFG_W'(10);
      fs_r       <= FS_W'(127);
      inv_r      <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_CENTER: center_r   <= cfg_ch.data;
        CFG_NEG:    neg_span_r <= cfg_ch.data;
        CFG_POS:    pos_span_r <= cfg_ch.data;
        CFG_MARGIN: margin_r   <= cfg_ch.data;
        CFG_FULL:   fs_r       <= cfg_ch.data[FS_W-1:0];
        CFG_INVERT: inv_r      <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic div_ready;

  logic [MAG_W:0]    s1_diff_r;
  logic [CFG_W:0]    s1_effp_r;
  logic [CFG_W:0]    s1_effn_r;
  logic [CFG_W-1:0]  s1_margin_r;
  logic [FS_W-1:0]   s1_fs_r;
  logic              s1_inv_r;

  logic [MAG_W-1:0]  s2_mag_r;
  logic [CFG_W-1:0]  s2_eff_r;
  logic              s2_effpos_r;
  logic [CFG_W-1:0]  s2_margin_r;
  logic              s2_neg_r;
  logic [FS_W-1:0]   s2_fs_r;

  logic [MAG_W-1:0]  s3_exc_r;
  logic [CFG_W-1:0]  s3_den_r;
  div_ctl_t          s3_ctl_r;

  logic [NUM_W-1:0]  s4_num_r;
  logic [CFG_W-1:0]  s4_den_r;
  div_ctl_t          s4_ctl_r;

  logic [MAG_W:0]    neg_diff;
  logic [CFG_W:0]    eff_sel;

  assign rdy4 = !v4_r || div_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  assign neg_diff = ~s1_diff_r + (MAG_W + 1)'(1);
  assign eff_sel  = s1_diff_r[MAG_W] ? s1_effn_r : s1_effp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_ch.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_diff_r   <= {1'b0, MAG_W'(in_ch.sample)} - {1'b0, MAG_W'(center_r)};
      s1_effp_r   <= {1'b0, pos_span_r} - {1'b0, margin_r};
      s1_effn_r   <= {1'b0, neg_span_r} - {1'b0, margin_r};
      s1_margin_r <= margin_r;
      s1_fs_r     <= fs_r;
      s1_inv_r    <= inv_r;
    end
    if (rdy2) begin
      s2_mag_r    <= s1_diff_r[MAG_W] ? neg_diff[MAG_W-1:0] : s1_diff_r[MAG_W-1:0];
      s2_eff_r    <= eff_sel[CFG_W-1:0];
      s2_effpos_r <= !eff_sel[CFG_W] && (eff_sel != '0);
      s2_margin_r <= s1_margin_r;
      s2_neg_r    <= s1_diff_r[MAG_W] ^ s1_inv_r;
      s2_fs_r     <= s1_fs_r;
    end
    if (rdy3) begin
      s3_exc_r      <= s2_mag_r - MAG_W'(s2_margin_r);
      s3_den_r      <= s2_eff_r;
      s3_ctl_r.neg  <= s2_neg_r;
      s3_ctl_r.zero <= (s2_mag_r <= MAG_W'(s2_margin_r)) || !s2_effpos_r;
      s3_ctl_r.fs   <= s2_fs_r;
    end
    if (rdy4) begin
      s4_num_r <= NUM_W'(s3_exc_r) * NUM_W'(s3_ctl_r.fs);
      s4_den_r <= s3_den_r;
      s4_ctl_r <= s3_ctl_r;
    end
  end

  sdz_divider #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_ready  (div_ready),
    .in_num    (s4_num_r),
    .in_den    (s4_den_r),
    .in_ctl    (s4_ctl_r),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.axis_value)
  );

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import sdz_pkg::*;

  localparam int SAMPLE_BITS = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;
  localparam int PHASES = 11;
  localparam int PHASE_ITEMS = 62;
  localparam int OUT_HOLD_CYCLES = 80;

  typedef enum logic [1:0] {
    STEP_WRITE,
    STEP_KNOWN,
    STEP_PREDICT
  } step_kind_t;

  typedef struct {
    step_kind_t               kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_W-1:0]         val;
    logic signed [AXIS_W-1:0] axis;
  } dir_step_t;

  logic clk;
  logic rst_n;

  sdz_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  sdz_out_if out_ch ();
  sdz_cfg_if cfg_ch ();

  stick_deadzone_scaler_top #(.SAMPLE_BITS(SAMPLE_BITS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Register copies that track every accepted write.
  logic [CFG_W-1:0] ctr_lvl;
  logic [CFG_W-1:0] neg_span_r;
  logic [CFG_W-1:0] pos_span_r;
  logic [CFG_W-1:0] dead_mg;
  logic [FS_W-1:0]  full_sc;
  logic             inv_axis;

  logic signed [AXIS_W-1:0] axis_expect_q[$];
  dir_step_t                dir_steps[$];

  bit idle_on;
  int out_hold_len;
  int n_samples;
  int n_results;
  int n_errors;
  int n_cfg_writes;
  int n_settings;
  int n_in_stalls;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d results still expected", $time, axis_expect_q.size());
    $display("FAIL stick_deadzone_scaler_top");
    $finish;
  end

  function automatic logic signed [AXIS_W-1:0] predict_axis(logic [SAMPLE_BITS-1:0] s);
    int dev;
    int mag;
    int span;
    int eff;
    int m;
    int v;
    dev = int'(s) - int'(ctr_lvl);
    mag = (dev < 0) ? -dev : dev;
    v = 0;
    if (mag > int'(dead_mg)) begin
      span = (dev > 0) ? int'(pos_span_r) : int'(neg_span_r);
      eff = span - int'(dead_mg);
      m = (eff <= 0) ? 0 : ((mag - int'(dead_mg)) * int'(full_sc)) / eff;
      if (m > int'(full_sc)) m = int'(full_sc);
      v = (dev > 0) ? m : -m;
    end
    if (inv_axis) v = -v;
    return v[AXIS_W-1:0];
  endfunction

  function automatic int draw_idle();
    return idle_on ? $urandom_range(0, 4) : 0;
  endfunction

  // Mostly samples around the centre and the dead-zone edges, with some over the full range.
  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    int pick;
    int s;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      s = $urandom_range(0, 4095);
    end else if (pick < 8) begin
      if ($urandom_range(0, 1)) s = int'(ctr_lvl) + $urandom_range(0, int'(pos_span_r) + 8);
      else s = int'(ctr_lvl) - $urandom_range(0, int'(neg_span_r) + 8);
    end else begin
      s = int'(dead_mg) - 1 + $urandom_range(0, 3);
      s = $urandom_range(0, 1) ? int'(ctr_lvl) + s : int'(ctr_lvl) - s;
    end
    if (s < 0) s = 0;
    if (s > 4095) s = 4095;
    return s[SAMPLE_BITS-1:0];
  endfunction

  task automatic add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    dir_step_t st;
    st.kind = STEP_WRITE;
    st.idx = idx;
    st.val = data;
    st.axis = '0;
    dir_steps.push_back(st);
  endtask

  task automatic add_sample(logic [SAMPLE_BITS-1:0] s, bit known,
                            logic signed [AXIS_W-1:0] axis);
    dir_step_t st;
    st.kind = known ? STEP_KNOWN : STEP_PREDICT;
    st.idx = '0;
    st.val = s;
    st.axis = axis;
    dir_steps.push_back(st);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    unique case (idx)
      CFG_CENTER: ctr_lvl = data;
      CFG_NEG:    neg_span_r = data;
      CFG_POS:    pos_span_r = data;
      CFG_MARGIN: dead_mg = data;
      CFG_FULL:   full_sc = data[FS_W-1:0];
      CFG_INVERT: inv_axis = data[0];
      default: ;
    endcase
    n_cfg_writes++;
  endtask

  task automatic cfg_release();
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic [SAMPLE_BITS-1:0] s, bit known,
                             logic signed [AXIS_W-1:0] axis);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    axis_expect_q.push_back(known ? axis : predict_axis(s));
    n_samples++;
  endtask

  task automatic in_release();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (axis_expect_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && !in_ch.ready) n_in_stalls++;
  end

  always @(posedge clk) begin
    logic signed [AXIS_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (axis_expect_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual axis_value %0d",
                 $time, out_ch.axis_value);
        n_errors++;
      end else begin
        want = axis_expect_q.pop_front();
        if (out_ch.axis_value !== want) begin
          $display("%0t: axis_value mismatch, expected %0d, actual %0d",
                   $time, want, out_ch.axis_value);
          n_errors++;
        end
      end
    end
  end

  initial begin
    int stall;
    int hold;
    out_ch.ready <= 1'b0;
    forever begin
      if (out_hold_len > 0) begin
        hold = out_hold_len;
        out_hold_len = 0;
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      stall = draw_idle();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    bit in_busy;
    bit cfg_busy;
    logic [CFG_W-1:0] c;
    logic [CFG_W-1:0] ns;
    logic [CFG_W-1:0] ps;
    logic [CFG_W-1:0] mg;
    logic [CFG_W-1:0] f;
    logic [CFG_W-1:0] iv;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_CENTER;
    cfg_ch.data  <= '0;
    ctr_lvl      = 12'd2048;
    neg_span_r   = 12'd115;
    pos_span_r   = 12'd115;
    dead_mg      = 12'd10;
    full_sc      = 7'd127;
    inv_axis     = 1'b0;
    idle_on      = 1'b1;
    out_hold_len = 0;
    in_busy      = 1'b0;
    cfg_busy     = 1'b0;

    // Reset values: centre 2048, spans 115, margin 10, full scale 127.
    add_sample(12'd2048, 1'b1, 8'sd0);
    add_sample(12'd2058, 1'b1, 8'sd0);
    add_sample(12'd2038, 1'b1, 8'sd0);
    add_sample(12'd2059, 1'b0, 8'sd0);
    add_sample(12'd2163, 1'b1, 8'sd127);
    add_sample(12'd1933, 1'b1, -8'sd127);
    add_sample(12'd4095, 1'b1, 8'sd127);
    add_sample(12'd0, 1'b1, -8'sd127);
    add_sample(12'd2100, 1'b0, 8'sd0);
    add_sample(12'd1990, 1'b0, 8'sd0);
    add_sample(12'hAAA, 1'b0, 8'sd0);
    add_sample(12'h555, 1'b0, 8'sd0);
    add_write(CFG_INVERT, 12'd1);
    add_sample(12'd4095, 1'b1, -8'sd127);
    add_sample(12'd0, 1'b1, 8'sd127);
    // Writes to unused indexes must leave every register alone.
    add_write(CFG_IDX_SPARE_A, 12'hFFF);
    add_write(CFG_IDX_SPARE_B, 12'h000);
    add_sample(12'd4095, 1'b1, -8'sd127);
    add_write(CFG_INVERT, 12'd0);
    add_write(CFG_POS, 12'd10);
    add_write(CFG_NEG, 12'd5);
    add_sample(12'd4095, 1'b1, 8'sd0);
    add_sample(12'd0, 1'b1, 8'sd0);
    add_write(CFG_CENTER, 12'd0);
    add_write(CFG_POS, 12'd4095);
    add_write(CFG_MARGIN, 12'd0);
    add_write(CFG_FULL, 12'd1);
    add_sample(12'd4095, 1'b1, 8'sd1);
    add_sample(12'd1, 1'b1, 8'sd0);
    add_sample(12'd0, 1'b1, 8'sd0);
    add_write(CFG_CENTER, 12'd4095);
    add_write(CFG_NEG, 12'd4095);
    add_write(CFG_FULL, 12'd127);
    add_sample(12'd0, 1'b1, -8'sd127);
    add_sample(12'd2048, 1'b0, 8'sd0);
    add_write(CFG_MARGIN, 12'd4095);
    add_sample(12'd0, 1'b1, 8'sd0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_steps[k]) begin
      if (dir_steps[k].kind == STEP_WRITE) begin
        if (in_busy) begin
          in_release();
          in_busy = 1'b0;
          wait_drained();
        end
        write_reg(dir_steps[k].idx, dir_steps[k].val);
        cfg_busy = 1'b1;
      end else begin
        if (cfg_busy) begin
          cfg_release();
          cfg_busy = 1'b0;
          n_settings++;
        end
        send_sample(dir_steps[k].val[SAMPLE_BITS-1:0], dir_steps[k].kind == STEP_KNOWN,
                    dir_steps[k].axis);
        in_busy = 1'b1;
      end
    end
    if (in_busy) in_release();
    if (cfg_busy) cfg_release();

    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p % 4 != 2);
      wait_drained();
      case (p)
        0: begin
          c = 12'd0; ns = 12'd0; ps = 12'd4095; mg = 12'd0; f = 12'd1; iv = 12'd0;
        end
        1: begin
          c = 12'd4095; ns = 12'd4095; ps = 12'd4095; mg = 12'd0; f = 12'd127; iv = 12'd1;
        end
        2: begin
          c = 12'd2048; ns = 12'd2047; ps = 12'd2047; mg = 12'd0; f = 12'd127; iv = 12'd0;
        end
        default: begin
          if (p % 2) begin
            c  = CFG_W'($urandom_range(512, 3583));
            ns = CFG_W'($urandom_range(1, 1500));
            ps = CFG_W'($urandom_range(1, 1500));
            mg = CFG_W'($urandom_range(0, 120));
          end else begin
            c  = CFG_W'($urandom_range(0, 4095));
            ns = CFG_W'($urandom_range(0, 4095));
            ps = CFG_W'($urandom_range(0, 4095));
            mg = CFG_W'($urandom_range(0, 4095));
          end
          f  = CFG_W'($urandom_range(1, 127));
          iv = CFG_W'($urandom_range(0, 1));
        end
      endcase
      if (p % 3 == 0) write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                                CFG_W'($urandom_range(0, 4095)));
      write_reg(CFG_CENTER, c);
      write_reg(CFG_NEG, ns);
      write_reg(CFG_POS, ps);
      write_reg(CFG_MARGIN, mg);
      write_reg(CFG_FULL, f);
      write_reg(CFG_INVERT, iv);
      cfg_release();
      n_settings++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // A long output hold backs the pipeline up into the input.
        if (p == 3 && i == 10) out_hold_len = OUT_HOLD_CYCLES;
        if (p == 6 && i == 30) begin
          in_release();
          wait_drained();
        end
        send_sample(rand_sample(), 1'b0, 8'sd0);
      end
      in_release();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Run covered %0d samples over %0d register settings (%0d register writes).",
             n_samples, n_settings, n_cfg_writes);
    $display("Checked %0d results; input was held off for %0d cycles by back-pressure.",
             n_results, n_in_stalls);
    if (n_errors == 0) begin
      $display("PASS stick_deadzone_scaler_top");
    end else begin
      $display("FAIL stick_deadzone_scaler_top");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sdz_pkg.sv
design/sdz_in_if.sv
design/sdz_out_if.sv
design/sdz_cfg_if.sv
design/sdz_divider.sv
design/stick_deadzone_scaler_top.sv
test/tb.sv
